[rtl/spc_pkg.sv]
// shared constants, types and helpers for the segmented pixel compressor
package spc_pkg;

    // history and cost sizing
    localparam int HISTORY_DEPTH = 256;
    localparam int COST_WIDTH    = 27;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int LEN_W         = $clog2(HISTORY_DEPTH + 1);

    // fixed field widths
    localparam int PIXEL_W    = 8;
    localparam int SEG_LEN_W  = 9;
    localparam int SEG_BITS_W = 4;
    localparam int MAX_SEG_W  = 9;
    localparam int HDR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // derived datapath widths
    localparam int ENTRY_W = SEG_BITS_W + COST_WIDTH;
    localparam int SUM_W   = COST_WIDTH + 1;
    localparam int LIM_W   = (LEN_W + 1 > MAX_SEG_W) ? LEN_W + 1 : MAX_SEG_W;
    localparam int PROD_W  = LEN_W + SEG_BITS_W;

    localparam logic [COST_WIDTH-1:0] COST_MAX = {COST_WIDTH{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BITS = CFG_IDX_W'(1);

    // register reset values
    localparam logic [MAX_SEG_W-1:0] MAX_SEG_RESET = MAX_SEG_W'(256);
    localparam logic [HDR_W-1:0]     HDR_RESET     = HDR_W'(12);

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_WRITE
    } spc_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_issue;
        logic pipe_busy;
    } ctrl_sts_t;

    // width of a pixel value, zero counts as one bit
    function automatic logic [SEG_BITS_W-1:0] bit_length(input logic [PIXEL_W-1:0] v);
        logic [SEG_BITS_W-1:0] n;
        n = SEG_BITS_W'(1);
        for (int i = 1; i < PIXEL_W; i++) begin
            if (v[i]) begin
                n = SEG_BITS_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

[rtl/spc_ram.sv]
// generic single-port-write, registered-read RAM
module spc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/spc_ctrl.sv]
// sequencing state machine for the segment cost scan
module spc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output spc_pkg::ctrl_cmd_t cmd,
    input  spc_pkg::ctrl_sts_t sts
);
    import spc_pkg::*;

    spc_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    // state and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (sts.last_issue) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // a result is only loaded into a free or draining output register
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending word");

    // a taken word without a new load leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !cmd.commit) |=> !m_valid_reg)
        else $error("output word repeated");
`endif

endmodule

[rtl/spc_dp.sv]
// history memory, candidate cost pipeline and best-segment tracking
module spc_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  spc_pkg::ctrl_cmd_t                 cmd,
    output spc_pkg::ctrl_sts_t                 sts,
    input  logic [spc_pkg::PIXEL_W-1:0]        s_pixel,
    input  logic                               s_start_of_image,
    input  logic                               cfg_valid,
    input  logic [spc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [spc_pkg::COST_WIDTH-1:0]     m_total_bits,
    output logic [spc_pkg::SEG_LEN_W-1:0]      m_seg_len,
    output logic [spc_pkg::SEG_BITS_W-1:0]     m_seg_bits
);
    import spc_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HISTORY_DEPTH - 1);
    localparam logic [LEN_W-1:0]  DEPTH_LEN = LEN_W'(HISTORY_DEPTH);

    // configuration
    logic [MAX_SEG_W-1:0] max_seg_reg;
    logic [HDR_W-1:0]     hdr_reg;

    // per-item control
    logic [ADDR_W-1:0]     head_reg;
    logic [LEN_W-1:0]      pos_reg;
    logic [SEG_BITS_W-1:0] w_reg;
    logic [LEN_W-1:0]      limit_reg;
    logic [ADDR_W-1:0]     k_reg;
    logic [ADDR_W-1:0]     raddr_reg;

    // read stage
    logic              rv_reg;
    logic [ADDR_W-1:0] rk_reg;
    logic [ENTRY_W-1:0] rdata;

    // candidate stage
    logic [SEG_BITS_W-1:0] prevw_reg;
    logic [SEG_BITS_W-1:0] bmax_reg;
    logic                  cv_reg;
    logic [COST_WIDTH-1:0] cand_reg;
    logic [LEN_W-1:0]      cand_len_reg;
    logic [SEG_BITS_W-1:0] cand_bits_reg;

    // best so far and output word
    logic [COST_WIDTH-1:0] best_reg;
    logic [LEN_W-1:0]      best_len_reg;
    logic [SEG_BITS_W-1:0] best_bits_reg;
    logic [COST_WIDTH-1:0] out_total_reg;
    logic [LEN_W-1:0]      out_len_reg;
    logic [SEG_BITS_W-1:0] out_bits_reg;

    // combinational helpers
    logic [LEN_W-1:0]      p_eff;
    logic [LIM_W-1:0]      lim_calc;
    logic [COST_WIDTH-1:0] cost_in;
    logic [SEG_BITS_W-1:0] width_in;
    logic [SEG_BITS_W-1:0] bmax_new;
    logic [LEN_W-1:0]      j_len;
    logic [PROD_W-1:0]     prod;
    logic [SUM_W-1:0]      sum;
    logic [COST_WIDTH-1:0] cand_sat;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_seg_reg <= MAX_SEG_RESET;
            hdr_reg     <= HDR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_SEGMENT: max_seg_reg <= cfg_data[MAX_SEG_W-1:0];
                REG_HEADER_BITS: hdr_reg     <= cfg_data[HDR_W-1:0];
                default: ;
            endcase
        end
    end

    // segment limit for the arriving pixel
    always_comb begin
        p_eff    = s_start_of_image ? '0 : pos_reg;
        lim_calc = LIM_W'(p_eff) + LIM_W'(1);
        if (lim_calc > LIM_W'(HISTORY_DEPTH)) begin
            lim_calc = LIM_W'(HISTORY_DEPTH);
        end
        if (LIM_W'(max_seg_reg) < lim_calc) begin
            lim_calc = LIM_W'(max_seg_reg);
        end
        if (lim_calc == '0) begin
            lim_calc = LIM_W'(1);
        end
    end

    // position count, head pointer and read address sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            pos_reg  <= '0;
            rv_reg   <= 1'b0;
        end else begin
            rv_reg <= cmd.issue;
            if (cmd.start) begin
                pos_reg <= p_eff;
            end
            if (cmd.commit) begin
                head_reg <= (head_reg == LAST_ADDR) ? '0 : head_reg + ADDR_W'(1);
                if (pos_reg != DEPTH_LEN) begin
                    pos_reg <= pos_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            w_reg     <= bit_length(s_pixel);
            limit_reg <= LEN_W'(lim_calc);
            k_reg     <= '0;
            raddr_reg <= (head_reg == '0) ? LAST_ADDR : head_reg - ADDR_W'(1);
        end else if (cmd.issue) begin
            k_reg     <= k_reg + ADDR_W'(1);
            raddr_reg <= (raddr_reg == '0) ? LAST_ADDR : raddr_reg - ADDR_W'(1);
        end
        rk_reg <= k_reg;
    end

    // history: {bit width, cost} per earlier position
    spc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (head_reg),
        .wdata ({w_reg, best_reg}),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    // candidate cost for segment length k+1
    always_comb begin
        width_in = rdata[ENTRY_W-1:COST_WIDTH];
        cost_in  = (LEN_W'(rk_reg) == pos_reg) ? '0 : rdata[COST_WIDTH-1:0];
        if (rk_reg == '0) begin
            bmax_new = w_reg;
        end else begin
            bmax_new = (prevw_reg > bmax_reg) ? prevw_reg : bmax_reg;
        end
        j_len    = LEN_W'(rk_reg) + LEN_W'(1);
        prod     = PROD_W'(j_len) * PROD_W'(bmax_new);
        sum      = SUM_W'(cost_in) + SUM_W'(prod) + SUM_W'(hdr_reg);
        cand_sat = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= 1'b0;
        end else begin
            cv_reg <= rv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rv_reg) begin
            prevw_reg     <= width_in;
            bmax_reg      <= bmax_new;
            cand_reg      <= cand_sat;
            cand_len_reg  <= j_len;
            cand_bits_reg <= bmax_new;
        end
    end

    // keep the strictly smaller cost, shortest segment first
    always_ff @(posedge aclk) begin
        if (cv_reg && (cand_len_reg == LEN_W'(1) || best_reg > cand_reg)) begin
            best_reg      <= cand_reg;
            best_len_reg  <= cand_len_reg;
            best_bits_reg <= cand_bits_reg;
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_total_reg <= best_reg;
            out_len_reg   <= best_len_reg;
            out_bits_reg  <= best_bits_reg;
        end
    end

    assign m_total_bits   = out_total_reg;
    assign m_seg_len      = SEG_LEN_W'(out_len_reg);
    assign m_seg_bits     = out_bits_reg;
    assign sts.last_issue = (LEN_W'(k_reg) == limit_reg - LEN_W'(1));
    assign sts.pipe_busy  = rv_reg || cv_reg;

`ifndef SYNTHESIS
    // reads never run past the segment limit
    a_issue_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (LEN_W'(k_reg) < limit_reg))
        else $error("history read beyond segment limit");

    // every candidate carries a legal width and length
    a_cand_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        cv_reg |-> (cand_bits_reg >= SEG_BITS_W'(1) && cand_bits_reg <= SEG_BITS_W'(8)
                    && cand_len_reg <= limit_reg))
        else $error("candidate width or length out of range");
`endif

endmodule

[rtl/segmented_pixel_compress_dp.sv]
// each pixel scans limit history entries via candidate and best registers into the output register
// a new pixel waits for the previous commit; the history scan reads one entry per cycle
// limit (segment search length) = min(pixels so far in image + 1, max_segment, 256), at least 1
// the output register lets the next pixel be taken while a result waits
// reset (aresetn low, synchronous): empty history, max_segment 256, header_bits 12
// no clearing pass: the position count masks history entries not yet written
module segmented_pixel_compress_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [spc_pkg::PIXEL_W-1:0]        s_pixel,
    input  logic                               s_start_of_image,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [spc_pkg::COST_WIDTH-1:0]     m_total_bits,
    output logic [spc_pkg::SEG_LEN_W-1:0]      m_seg_len,
    output logic [spc_pkg::SEG_BITS_W-1:0]     m_seg_bits,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import spc_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // sequencer
    spc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath
    spc_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_pixel          (s_pixel),
        .s_start_of_image (s_start_of_image),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_total_bits     (m_total_bits),
        .m_seg_len        (m_seg_len),
        .m_seg_bits       (m_seg_bits)
    );

endmodule
